### rtl/core/abc_pkg.sv
// abc_pkg: shared types, status and register codes for the accel bias calibration block
// no dependencies; imported by the lane, merge and top level modules
`timescale 1ns / 1ps

package abc_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [16:0] corr_t;
  typedef logic signed [32:0] scaled_t;
  typedef logic [23:0]        gain_t;
  typedef logic [1:0]         status_t;
  typedef logic [1:0]         reg_idx_t;

  localparam status_t STATUS_SAMPLE  = 2'd0;
  localparam status_t STATUS_UPDATED = 2'd1;
  localparam status_t STATUS_REFUSED = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CAL    = 1'b1;

  localparam reg_idx_t REG_TARGET_X   = 2'd0;
  localparam reg_idx_t REG_TARGET_Y   = 2'd1;
  localparam reg_idx_t REG_TARGET_Z   = 2'd2;
  localparam reg_idx_t REG_SCALE_GAIN = 2'd3;

  localparam sample_t TARGET_X_RST   = 16'sd0;
  localparam sample_t TARGET_Y_RST   = 16'sd0;
  localparam sample_t TARGET_Z_RST   = 16'sd16384;
  localparam gain_t   SCALE_GAIN_RST = 24'd10035;

  // sequencer strobes shared by all three axis lanes
  typedef struct packed {
    logic sum_clr;
    logic rd_go;
    logic div_load;
    logic div_step;
    logic bias_load;
  } lane_ctl_t;

  // tag that rides with a result beat through the merge stage
  typedef struct packed {
    status_t status;
    logic    is_cal;
    logic    full;
  } beat_tag_t;

endpackage

### rtl/core/abc_ram.sv
// abc_ram: generic single write port, single read port ram with registered read
// no dependencies; used for the per-axis sample windows
`timescale 1ns / 1ps

module abc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/abc_lane.sv
// abc_lane: one axis lane: sample window, bias register, window sum and
// reciprocal multiply by the window length; depends on abc_pkg and abc_ram
`timescale 1ns / 1ps

module abc_lane #(
  parameter int WINDOW = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  abc_pkg::lane_ctl_t  ctl,
  input  logic                wr_en,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] wr_addr,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] rd_addr,
  input  abc_pkg::sample_t    sample,
  input  abc_pkg::sample_t    target,
  output abc_pkg::corr_t      corr,
  output abc_pkg::sample_t    bias
);
  import abc_pkg::*;

  localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUMW = 17 + $clog2(WINDOW);
  localparam int MAGW = SUMW - 1;
  // ceil(2**RSH / WINDOW) gives the exact quotient for any magnitude below 2**MAGW
  localparam int RSH  = MAGW + $clog2(WINDOW);
  localparam longint RECIP = ((longint'(1) << RSH) + longint'(WINDOW) - 1) / longint'(WINDOW);
  localparam logic [MAGW:0] RECIP_M = (MAGW + 1)'(RECIP);
  localparam int PW   = 2 * MAGW + 1;

  logic [15:0]             rd_data;
  logic                    acc_v_r;
  logic signed [SUMW-1:0]  sum_r, sum_nxt;
  logic [MAGW-1:0]         mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [PW-1:0]           prod;
  logic [16:0]             q_r, q_nxt;
  logic signed [17:0]      avg;
  logic signed [17:0]      diff;
  sample_t                 bias_r, bias_nxt;

  abc_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign corr = corr_t'(sample) + corr_t'(bias_r);
  assign bias = bias_r;

  // ram read data lands in the cycle after the address
  always_comb begin
    sum_nxt = sum_r;
    if (ctl.sum_clr) begin
      sum_nxt = '0;
    end else if (acc_v_r) begin
      sum_nxt = sum_r + SUMW'($signed(rd_data));
    end
  end

  // sum magnitude first, then a multiply by the window reciprocal
  always_comb begin
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    q_nxt   = q_r;
    prod    = PW'(mag_r) * PW'(RECIP_M);
    if (ctl.div_load) begin
      neg_nxt = sum_r[SUMW-1];
      mag_nxt = sum_r[SUMW-1] ? MAGW'(-sum_r) : MAGW'(sum_r);
    end else if (ctl.div_step) begin
      q_nxt = prod[RSH +: 17];
    end
  end

  // truncating average, then target minus average saturated to 16 bits
  always_comb begin
    avg  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    diff = 18'(target) - avg;
    bias_nxt = bias_r;
    if (ctl.bias_load) begin
      if (diff > 18'sd32767) begin
        bias_nxt = 16'sd32767;
      end else if (diff < -18'sd32768) begin
        bias_nxt = -16'sd32768;
      end else begin
        bias_nxt = diff[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r <= 1'b0;
      bias_r  <= '0;
    end else begin
      acc_v_r <= ctl.rd_go;
      bias_r  <= bias_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

endmodule

### rtl/core/abc_merge.sv
// abc_merge: gathers the three lane results into one beat, applies the gain
// multiply and holds the output register; depends on abc_pkg
`timescale 1ns / 1ps

module abc_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  abc_pkg::beat_tag_t  tag,
  input  abc_pkg::corr_t      corr_x,
  input  abc_pkg::corr_t      corr_y,
  input  abc_pkg::corr_t      corr_z,
  input  abc_pkg::gain_t      gain,
  output logic                s1_free,
  output logic                out_valid,
  input  logic                out_stall,
  output abc_pkg::status_t    out_status,
  output abc_pkg::corr_t      out_corrected_x,
  output abc_pkg::corr_t      out_corrected_y,
  output abc_pkg::corr_t      out_corrected_z,
  output abc_pkg::scaled_t    out_scaled_x,
  output abc_pkg::scaled_t    out_scaled_y,
  output abc_pkg::scaled_t    out_scaled_z,
  output logic                out_window_full
);
  import abc_pkg::*;

  logic               s1_v_r;
  beat_tag_t          s1_tag_r;
  corr_t              s1_corr_r [3];
  corr_t              corr_in   [3];
  logic signed [40:0] prod      [3];
  scaled_t            scaled    [3];
  logic               out_v_r;
  beat_tag_t          out_tag_r;
  corr_t              out_corr_r   [3];
  scaled_t            out_scaled_r [3];
  logic               out_adv;
  logic               s1_adv;

  assign out_adv = !out_v_r || !out_stall;
  assign s1_adv  = s1_v_r && out_adv;
  assign s1_free = !s1_v_r || out_adv;

  assign corr_in[0] = corr_x;
  assign corr_in[1] = corr_y;
  assign corr_in[2] = corr_z;

  // q16.16 result is the q.24 product shifted right by 8, rounding to minus infinity
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]   = 41'(s1_corr_r[i]) * 41'($signed({1'b0, gain}));
      scaled[i] = s1_tag_r.is_cal ? '0 : prod[i][40:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_tag_r <= tag;
      for (int i = 0; i < 3; i++) begin
        s1_corr_r[i] <= corr_in[i];
      end
    end
    if (s1_adv) begin
      out_tag_r <= s1_tag_r;
      for (int i = 0; i < 3; i++) begin
        out_corr_r[i]   <= s1_corr_r[i];
        out_scaled_r[i] <= scaled[i];
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = out_tag_r.status;
  assign out_window_full = out_tag_r.full;
  assign out_corrected_x = out_corr_r[0];
  assign out_corrected_y = out_corr_r[1];
  assign out_corrected_z = out_corr_r[2];
  assign out_scaled_x    = out_scaled_r[0];
  assign out_scaled_y    = out_scaled_r[1];
  assign out_scaled_z    = out_scaled_r[2];

endmodule

### rtl/core/accel_bias_calibration.sv
// accel_bias_calibration: top level, config registers, window pointer and the
// calibrate sequencer; depends on abc_pkg, abc_lane, abc_merge
//
//   port group  direction  handshake           payload
//   in_*        input      in_valid/in_stall   func, sample_x/y/z
//   out_*       output     out_valid/out_stall status, corrected_x/y/z, scaled_x/y/z, window_full
//   cfg_*       input      cfg_we              cfg_index, cfg_wdata
//
// a sample beat is taken every cycle unless stalled; its result is registered in s1, then in out
// a calibrate beat on a full window holds in_stall high through the calibrate sequence:
// one ram read a cycle over the window, then the drain, magnitude,
// reciprocal multiply, bias and emit steps; emit waits while the merge stage is full
// a refused calibrate passes through like a sample
// out_stall backs up through the two result stages into in_stall
// rst_n clears pointer, full flag, biases and registers to their defaults
`timescale 1ns / 1ps

module accel_bias_calibration #(
  parameter int WINDOW = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  abc_pkg::sample_t  in_sample_x,
  input  abc_pkg::sample_t  in_sample_y,
  input  abc_pkg::sample_t  in_sample_z,
  output logic              out_valid,
  input  logic              out_stall,
  output abc_pkg::status_t  out_status,
  output abc_pkg::corr_t    out_corrected_x,
  output abc_pkg::corr_t    out_corrected_y,
  output abc_pkg::corr_t    out_corrected_z,
  output abc_pkg::scaled_t  out_scaled_x,
  output abc_pkg::scaled_t  out_scaled_y,
  output abc_pkg::scaled_t  out_scaled_z,
  output logic              out_window_full,
  input  logic              cfg_we,
  input  abc_pkg::reg_idx_t cfg_index,
  input  abc_pkg::gain_t    cfg_wdata
);
  import abc_pkg::*;

  localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNTW = $clog2(WINDOW + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_BIAS  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  sample_t       target_x_r, target_y_r, target_z_r;
  gain_t         gain_r;
  logic [2:0]    state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic          full_r, full_nxt;
  logic          slot_wrap;
  logic          in_accept;
  logic          wr_en;
  logic          load;
  logic          use_corr;
  logic          s1_free;
  beat_tag_t     tag;
  lane_ctl_t     ctl;
  corr_t         lane_corr_x, lane_corr_y, lane_corr_z;
  sample_t       bias_x, bias_y, bias_z;
  corr_t         sel_x, sel_y, sel_z;

  assign in_stall  = (state_r != S_IDLE) || !s1_free;
  assign in_accept = in_valid && !in_stall;
  assign slot_wrap = (slot_r == AW'(WINDOW - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    full_nxt  = full_r;
    wr_en     = 1'b0;
    load      = 1'b0;
    use_corr  = 1'b0;
    tag       = '0;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_func == FUNC_SAMPLE) begin
            wr_en    = 1'b1;
            slot_nxt = slot_wrap ? '0 : slot_r + AW'(1);
            full_nxt = full_r || slot_wrap;
            load     = 1'b1;
            use_corr = 1'b1;
            tag      = '{status: STATUS_SAMPLE, is_cal: 1'b0, full: full_r || slot_wrap};
          end else if (full_r) begin
            ctl.sum_clr = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = S_READ;
          end else begin
            load = 1'b1;
            tag  = '{status: STATUS_REFUSED, is_cal: 1'b1, full: full_r};
          end
        end
      end
      S_READ: begin
        ctl.rd_go = 1'b1;
        if (cnt_r == CNTW'(WINDOW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      S_DRAIN: begin
        // last read word is still being added in
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        ctl.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        state_nxt    = S_BIAS;
      end
      S_BIAS: begin
        ctl.bias_load = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (s1_free) begin
          load      = 1'b1;
          tag       = '{status: STATUS_UPDATED, is_cal: 1'b1, full: full_r};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      slot_r     <= '0;
      full_r     <= 1'b0;
      target_x_r <= TARGET_X_RST;
      target_y_r <= TARGET_Y_RST;
      target_z_r <= TARGET_Z_RST;
      gain_r     <= SCALE_GAIN_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      slot_r  <= slot_nxt;
      full_r  <= full_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET_X:   target_x_r <= cfg_wdata[15:0];
          REG_TARGET_Y:   target_y_r <= cfg_wdata[15:0];
          REG_TARGET_Z:   target_z_r <= cfg_wdata[15:0];
          REG_SCALE_GAIN: gain_r     <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  abc_lane #(.WINDOW(WINDOW)) u_lane_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .rd_addr (cnt_r[AW-1:0]),
    .sample  (in_sample_x),
    .target  (target_x_r),
    .corr    (lane_corr_x),
    .bias    (bias_x)
  );

  abc_lane #(.WINDOW(WINDOW)) u_lane_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .rd_addr (cnt_r[AW-1:0]),
    .sample  (in_sample_y),
    .target  (target_y_r),
    .corr    (lane_corr_y),
    .bias    (bias_y)
  );

  abc_lane #(.WINDOW(WINDOW)) u_lane_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .rd_addr (cnt_r[AW-1:0]),
    .sample  (in_sample_z),
    .target  (target_z_r),
    .corr    (lane_corr_z),
    .bias    (bias_z)
  );

  // calibrate beats report the bias in use, sign extended
  assign sel_x = use_corr ? lane_corr_x : corr_t'(bias_x);
  assign sel_y = use_corr ? lane_corr_y : corr_t'(bias_y);
  assign sel_z = use_corr ? lane_corr_z : corr_t'(bias_z);

  abc_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .tag             (tag),
    .corr_x          (sel_x),
    .corr_y          (sel_y),
    .corr_z          (sel_z),
    .gain            (gain_r),
    .s1_free         (s1_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_corrected_x (out_corrected_x),
    .out_corrected_y (out_corrected_y),
    .out_corrected_z (out_corrected_z),
    .out_scaled_x    (out_scaled_x),
    .out_scaled_y    (out_scaled_y),
    .out_scaled_z    (out_scaled_z),
    .out_window_full (out_window_full)
  );

endmodule
